### rtl/bfiq_pkg.sv
// Shared constants and codes of the Bloom filter insert and query block.
package bfiq_pkg;

    localparam int unsigned MAX_BITS   = 1048576;
    localparam int unsigned MAX_PROBES = 16;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned DIV_W   = 21;
    localparam int unsigned IDX_W   = $clog2(MAX_BITS);
    localparam int unsigned PROBE_W = 5;
    localparam int unsigned ACT_W   = 2;

    localparam int unsigned ROW_W    = 64;
    localparam int unsigned ROW_BITS = $clog2(ROW_W);
    localparam int unsigned ROWS     = MAX_BITS / ROW_W;
    localparam int unsigned ROW_AW   = IDX_W - ROW_BITS;

    localparam int unsigned DIV_CYCLES = HASH_W / 2;
    localparam int unsigned CNT_W      = $clog2(DIV_CYCLES);

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = DIV_W;

    typedef logic [ACT_W-1:0]     t_action;
    typedef logic [CFG_IDX_W-1:0] t_cfg_index;

    localparam t_action ACT_ADD   = 2'd0;
    localparam t_action ACT_QUERY = 2'd1;
    localparam t_action ACT_CLEAR = 2'd2;

    localparam t_cfg_index REG_FILTER_BITS = 1'b0;
    localparam t_cfg_index REG_NUM_HASHES  = 1'b1;

    localparam logic [DIV_W-1:0]   RST_FILTER_BITS = DIV_W'(1048576);
    localparam logic [PROBE_W-1:0] RST_NUM_HASHES  = PROBE_W'(7);

endpackage

### rtl/bloom_filter_insert_query.sv
// Bloom filter bit store with double hashing, add, query and clear actions.
// Each item carries an action and a 128-bit key hash split into hash_a and hash_b; probe n
// reads or sets bit (hash_a + n*hash_b) mod filter_bits, the sum wrapping at 64 bits, and
// every item returns one result beat. One shared remainder unit takes two dividend bits a
// cycle; each probe runs the remainder, then a row read, then the check or the row write,
// and a query stops at its first clear bit. The bits sit in a memory of 16384 rows of
// 64 bits, written one row per cycle by a clearing pass that a clear action runs and that
// the block also runs right after reset before it takes any item.
// Configuration writes are accepted in every cycle and must only be issued while idle.
module bloom_filter_insert_query
    import bfiq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [ACT_W-1:0]      i_action,
    input  logic [HASH_W-1:0]     i_hash_a,
    input  logic [HASH_W-1:0]     i_hash_b,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_maybe_present,
    output logic                  o_done_res,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_READ   = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);
    localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(DIV_CYCLES - 1);

    logic [ROW_W-1:0] r_mem [ROWS];

    logic [2:0]         r_state, n_state;
    logic               r_pend, n_pend;
    logic [ROW_AW-1:0]  r_row, n_row;
    logic               r_out_valid;
    logic               r_out_present;
    logic [DIV_W-1:0]   r_filter_bits;
    logic [PROBE_W-1:0] r_num_hashes;

    t_action            r_act, n_act;
    logic [DIV_W-1:0]   r_mod, n_mod;
    logic [PROBE_W-1:0] r_k, n_k;
    logic [PROBE_W-1:0] r_probe, n_probe;
    logic [HASH_W-1:0]  r_sum, n_sum;
    logic [HASH_W-1:0]  r_b, n_b;
    logic [HASH_W-1:0]  r_dvd, n_dvd;
    logic [DIV_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_present, n_present;
    logic [ROW_W-1:0]   r_rd;

    logic               w_in_fire;
    logic               w_fin;
    logic               w_we;
    logic [ROW_AW-1:0]  w_waddr;
    logic [ROW_W-1:0]   w_wdata;
    logic [DIV_W-1:0]   w_mod_use;
    logic [PROBE_W-1:0] w_k_use;
    logic [PROBE_W-1:0] w_probe_nx;
    logic [HASH_W-1:0]  w_sum_nx;
    logic               w_hit;
    logic [ROW_W-1:0]   w_mask;
    logic [DIV_W-1:0]   w_rem_half;

    function automatic logic [DIV_W-1:0] f_rem_step(
        input logic [DIV_W-1:0] rem,
        input logic             bit_in,
        input logic [DIV_W-1:0] m
    );
        logic [DIV_W:0] t;
        t = {rem, bit_in};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        return t[DIV_W-1:0];
    endfunction

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = r_out_valid;
    assign o_maybe_present = r_out_present;
    assign o_done_res      = 1'b1;

    assign w_in_fire  = i_valid && !o_stall;
    assign w_probe_nx = r_probe + PROBE_W'(1);
    assign w_sum_nx   = r_sum + r_b;
    assign w_hit      = r_rd[r_rem[ROW_BITS-1:0]];
    assign w_mask     = ROW_W'(1) << r_rem[ROW_BITS-1:0];
    assign w_rem_half = f_rem_step(r_rem, r_dvd[HASH_W-1], r_mod);

    always_comb begin
        if (r_filter_bits == '0) begin
            w_mod_use = DIV_W'(1);
        end else if (r_filter_bits > DIV_W'(MAX_BITS)) begin
            w_mod_use = DIV_W'(MAX_BITS);
        end else begin
            w_mod_use = r_filter_bits;
        end
        if (r_num_hashes > PROBE_W'(MAX_PROBES)) begin
            w_k_use = PROBE_W'(MAX_PROBES);
        end else begin
            w_k_use = r_num_hashes;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_pend    = r_pend;
        n_row     = r_row;
        n_act     = r_act;
        n_mod     = r_mod;
        n_k       = r_k;
        n_probe   = r_probe;
        n_sum     = r_sum;
        n_b       = r_b;
        n_dvd     = r_dvd;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_present = r_present;
        w_fin     = 1'b0;
        w_we      = 1'b0;
        w_waddr   = r_row;
        w_wdata   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_act     = i_action;
                    n_sum     = i_hash_a;
                    n_b       = i_hash_b;
                    n_dvd     = i_hash_a;
                    n_mod     = w_mod_use;
                    n_k       = w_k_use;
                    n_probe   = '0;
                    n_rem     = '0;
                    n_cnt     = '0;
                    n_present = (i_action == ACT_QUERY);
                    priority if (i_action == ACT_CLEAR) begin
                        n_row   = '0;
                        n_pend  = 1'b1;
                        n_state = S_CLEAR;
                    end else if ((i_action == ACT_ADD || i_action == ACT_QUERY)
                                 && w_k_use != '0) begin
                        n_state = S_DIV;
                    end else begin
                        n_state = S_FINISH;
                    end
                end
            end
            S_CLEAR: begin
                w_we  = 1'b1;
                n_row = r_row + ROW_AW'(1);
                if (r_row == ROW_LAST) begin
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_FINISH : S_IDLE;
                end
            end
            S_DIV: begin
                n_rem = f_rem_step(w_rem_half, r_dvd[HASH_W-2], r_mod);
                n_dvd = r_dvd << 2;
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_act == ACT_ADD) begin
                    w_we    = 1'b1;
                    w_waddr = r_rem[IDX_W-1:ROW_BITS];
                    w_wdata = r_rd | w_mask;
                end
                priority if (r_act == ACT_QUERY && !w_hit) begin
                    n_present = 1'b0;
                    n_state   = S_FINISH;
                end else if (w_probe_nx == r_k) begin
                    n_state = S_FINISH;
                end else begin
                    n_probe = w_probe_nx;
                    n_sum   = w_sum_nx;
                    n_dvd   = w_sum_nx;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    w_fin   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pend      <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_row   <= n_row;
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bits <= RST_FILTER_BITS;
            r_num_hashes  <= RST_NUM_HASHES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FILTER_BITS: r_filter_bits <= i_cfg_data;
                REG_NUM_HASHES:  r_num_hashes  <= i_cfg_data[PROBE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_mod     <= n_mod;
        r_k       <= n_k;
        r_probe   <= n_probe;
        r_sum     <= n_sum;
        r_b       <= n_b;
        r_dvd     <= n_dvd;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_present <= n_present;
        if (w_fin) begin
            r_out_present <= r_present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[r_rem[IDX_W-1:ROW_BITS]];
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> o_stall)
        else $error("block took an item but did not leave idle");

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_rem < r_mod))
        else $error("probe remainder is not below the divisor");

    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_probe < r_k))
        else $error("probe counter ran past the probe count");

    a_result_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> (o_valid && r_state == S_IDLE))
        else $error("finished item did not present its result beat");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the Bloom filter insert and query block.
module tb;
    import bfiq_pkg::*;

    localparam t_action     ACT_UNUSED   = 2'd3;
    localparam int unsigned STUCK_LIMIT  = 100000;
    localparam int unsigned SETTLE_TICKS = 600;
    localparam int unsigned KEY_KEEP     = 64;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    logic [ACT_W-1:0]      i_action    = '0;
    logic [HASH_W-1:0]     i_hash_a    = '0;
    logic [HASH_W-1:0]     i_hash_b    = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    logic                  o_maybe_present;
    logic                  o_done_res;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bit                    filter_store [int unsigned];
    logic [DIV_W-1:0]      cur_filter_bits = RST_FILTER_BITS;
    logic [PROBE_W-1:0]    cur_num_hashes  = RST_NUM_HASHES;
    bit                    pending_answers [$];
    logic [127:0]          known_keys [$];
    int unsigned           mismatches = 0;
    int unsigned           stuck_ticks = 0;
    bit                    steady = 1'b0;
    int unsigned           stall_run = 0;

    bloom_filter_insert_query dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 50);
    endfunction

    function automatic logic [HASH_W-1:0] rand_hash();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return HASH_W'($urandom_range(0, 255));
        return {$urandom, $urandom};
    endfunction

    // Applies one action to the shadow bit store and returns the expected
    // maybe_present answer.
    function automatic bit apply_action(t_action act, logic [HASH_W-1:0] a,
                                        logic [HASH_W-1:0] b);
        logic [HASH_W-1:0] divisor;
        logic [HASH_W-1:0] spot;
        int unsigned       probes;
        bit                hit;
        if (cur_filter_bits == 0) divisor = 1;
        else if (cur_filter_bits > MAX_BITS) divisor = MAX_BITS;
        else divisor = cur_filter_bits;
        probes = (cur_num_hashes > MAX_PROBES) ? MAX_PROBES : cur_num_hashes;
        hit = 1'b0;
        case (act)
            ACT_ADD: begin
                for (int n = 0; n < probes; n++) begin
                    spot = (a + HASH_W'(n) * b) % divisor;
                    filter_store[int'(spot)] = 1'b1;
                end
            end
            ACT_QUERY: begin
                hit = 1'b1;
                for (int n = 0; n < probes; n++) begin
                    spot = (a + HASH_W'(n) * b) % divisor;
                    if (!filter_store.exists(int'(spot))) begin
                        hit = 1'b0;
                        break;
                    end
                end
            end
            ACT_CLEAR: filter_store.delete();
            default: ;
        endcase
        return hit;
    endfunction

    task automatic send_item(t_action act, logic [HASH_W-1:0] a, logic [HASH_W-1:0] b);
        int unsigned gap;
        gap = idle_span();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_hash_a <= a;
        i_hash_b <= b;
        do @(posedge i_clk); while (o_stall);
        pending_answers.push_back(apply_action(act, a, b));
    endtask

    task automatic wait_quiet();
        if (i_valid) i_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic reconfigure(logic [DIV_W-1:0] fb, logic [CFG_DATA_W-1:0] nh_word);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_FILTER_BITS;
        i_cfg_data  <= fb;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_filter_bits = fb;
        i_cfg_index <= REG_NUM_HASHES;
        i_cfg_data  <= nh_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        cur_num_hashes = nh_word[PROBE_W-1:0];
        i_cfg_valid <= 1'b0;
    endtask

    task automatic note_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                note_mismatch("result beat with no item outstanding");
            end else begin
                want = pending_answers.pop_front();
                if (o_maybe_present !== want || o_done_res !== 1'b1)
                    note_mismatch($sformatf("maybe_present exp %0b got %0b, done exp 1 got %0b",
                                            want, o_maybe_present, o_done_res));
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (stall_run > 0) begin
            stall_run--;
        end else if (steady || $urandom_range(0, 9) < 7) begin
            i_stall   <= 1'b0;
            stall_run = $urandom_range(0, 5);
        end else begin
            i_stall   <= 1'b1;
            stall_run = idle_span();
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            stuck_ticks = 0;
        else
            stuck_ticks++;
        if (stuck_ticks >= STUCK_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_reset_config_extremes();
        send_item(ACT_QUERY, '0, '0);
        send_item(ACT_QUERY, '1, '1);
        send_item(ACT_ADD, '0, '0);
        send_item(ACT_QUERY, '0, '0);
        send_item(ACT_QUERY, '0, 64'd1);
        send_item(ACT_ADD, '1, '1);
        send_item(ACT_QUERY, '1, '1);
        send_item(ACT_ADD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_item(ACT_QUERY, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
        send_item(ACT_QUERY, 64'h0000_0000_0000_0001, 64'h8000_0000_0000_0001);
    endtask

    task automatic test_unused_action();
        send_item(ACT_UNUSED, 64'd5, 64'd3);
        send_item(ACT_QUERY, 64'd5, 64'd3);
    endtask

    task automatic test_clear();
        send_item(ACT_CLEAR, rand_hash(), rand_hash());
        send_item(ACT_QUERY, '1, '1);
    endtask

    task automatic test_zero_divisor();
        reconfigure('0, 21'd1);
        send_item(ACT_QUERY, rand_hash(), rand_hash());
        send_item(ACT_ADD, rand_hash(), rand_hash());
        send_item(ACT_QUERY, rand_hash(), rand_hash());
    endtask

    task automatic test_no_probes();
        reconfigure(21'd64, '0);
        send_item(ACT_ADD, 64'd17, 64'd1);
        send_item(ACT_QUERY, rand_hash(), rand_hash());
    endtask

    task automatic test_oversize_config();
        reconfigure('1, 21'd31);
        send_item(ACT_ADD, '1, 64'd12345);
        send_item(ACT_QUERY, '1, 64'd12345);
    endtask

    task automatic test_resize_keeps_bits();
        reconfigure(21'd64, 21'd4);
        send_item(ACT_ADD, 64'd3, 64'd5);
        reconfigure(21'd1048576, 21'd4);
        send_item(ACT_QUERY, 64'd3, 64'd5);
        send_item(ACT_QUERY, 64'd3, 64'd6);
    endtask

    task automatic test_random_traffic(logic [DIV_W-1:0] fb, logic [CFG_DATA_W-1:0] nh_word,
                                       int unsigned count, bit no_idle);
        logic [127:0] key;
        int unsigned  r;
        reconfigure(fb, nh_word);
        steady = no_idle;
        repeat (count) begin
            r = $urandom_range(0, 199);
            if (r < 2) begin
                send_item(ACT_CLEAR, rand_hash(), rand_hash());
            end else if (r < 6) begin
                send_item(ACT_UNUSED, rand_hash(), rand_hash());
            end else if (r < 90) begin
                key = {rand_hash(), rand_hash()};
                known_keys.push_back(key);
                if (known_keys.size() > KEY_KEEP) void'(known_keys.pop_front());
                send_item(ACT_ADD, key[127:64], key[63:0]);
            end else if (r < 165 && known_keys.size() > 0) begin
                key = known_keys[$urandom_range(0, known_keys.size() - 1)];
                send_item(ACT_QUERY, key[127:64], key[63:0]);
            end else begin
                send_item(ACT_QUERY, rand_hash(), rand_hash());
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_config_extremes();
        test_unused_action();
        test_clear();
        test_zero_divisor();
        test_no_probes();
        test_oversize_config();
        test_resize_keeps_bits();
        test_random_traffic(21'd1048576, 21'd7, 150, 1'b0);
        test_random_traffic(21'd64, 21'd16, 150, 1'b1);
        test_random_traffic(21'd1, 21'd3, 100, 1'b0);
        test_random_traffic(21'($urandom), 21'($urandom), 150, 1'b0);
        test_random_traffic(21'd1000, {16'($urandom), 5'd31}, 150, 1'b0);
        test_random_traffic(21'($urandom_range(2, 4096)), 21'($urandom_range(1, 16)),
                            200, 1'b0);
        wait_quiet();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
